/* hdl/dual_wheel_velocity_pid_top_defines.svh */
// Assertion macros for the dual-wheel velocity PID block.
// Used by dual_wheel_velocity_pid_top; expects clk and arst_n in scope.
`ifndef DUAL_WHEEL_VELOCITY_PID_TOP_DEFINES_SVH
`define DUAL_WHEEL_VELOCITY_PID_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DWVP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dwvp: property violated");
`define DWVP_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dwvp: forbidden condition seen");
`else
`define DWVP_ASSERT(lbl, prop)
`define DWVP_NEVER(lbl, expr)
`endif
`endif

/* hdl/dwvp_pkg.sv */
// Shared types, codes and widths for the dual-wheel velocity PID block.
// No dependencies; imported by every module of the block.
`default_nettype none
package dwvp_pkg;

	// field widths
	localparam int CMD_W      = 3;
	localparam int POS_W      = 32;
	localparam int DUTY_OUT_W = 12;
	localparam int GAIN_W     = 24;
	localparam int REG_W      = 32;
	localparam int IDX_W      = 3;

	// error accumulator, split in two halves for the shared multiplier
	localparam int SUM_W = 48;
	localparam int LO_W  = SUM_W / 2;
	localparam int HI_W  = SUM_W - LO_W;

	localparam int DUTY_MAX = 4095;
	localparam int DUTY_W   = 16;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 61;
	localparam int KIS_W  = (SUM_W + 26 > PROD_W) ? SUM_W + 26 : PROD_W;
	localparam int PID_W  = 20;
	localparam logic [PID_W-1:0] PID_CAP = PID_W'(10 << 16);

	// commands
	localparam logic [CMD_W-1:0] CMD_FWD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
	localparam logic [IDX_W-1:0] REG_LINEAR_SCALE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_ANGULAR_SCALE  = 3'd4;
	localparam logic [IDX_W-1:0] REG_LINEAR_TARGET  = 3'd5;
	localparam logic [IDX_W-1:0] REG_ANGULAR_TARGET = 3'd6;
	localparam logic [IDX_W-1:0] REG_DUTY_SCALE     = 3'd7;

	// reset values
	localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 24'd65536;
	localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 24'd6554;
	localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 24'd655360;
	localparam logic [REG_W-1:0]  RST_SCALE      = 32'd65536;
	localparam logic [REG_W-1:0]  RST_TARGET     = 32'd65536;
	localparam logic [REG_W-1:0]  RST_DUTY_SCALE = 32'd26836992;

	typedef struct packed {
		logic [GAIN_W-1:0]       prop_gain;
		logic [GAIN_W-1:0]       integ_gain;
		logic [GAIN_W-1:0]       deriv_gain;
		logic [REG_W-1:0]        linear_scale;
		logic [REG_W-1:0]        angular_scale;
		logic signed [REG_W-1:0] linear_target;
		logic signed [REG_W-1:0] angular_target;
		logic [REG_W-1:0]        duty_scale;
	} cfg_regs_t;

	// datapath sequence, one entry per cycle for each wheel
	typedef enum logic [3:0] {
		ST_DELTA,
		ST_MSPD,
		ST_ERR,
		ST_KP,
		ST_KD,
		ST_KIH,
		ST_KIL,
		ST_KIS,
		ST_ACC,
		ST_PID,
		ST_MDUTY,
		ST_DUTY
	} step_t;

	typedef struct packed {
		logic  accept;
		logic  motion;
		logic  clear;
		logic  run;
		logic  wheel;
		step_t step;
		logic  load_out;
	} dp_cmd_t;

endpackage
`default_nettype wire

/* hdl/dwvp_regs.sv */
// Configuration register file for the velocity PID block.
// Depends on dwvp_pkg.
`default_nettype none
module dwvp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dwvp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [dwvp_pkg::REG_W-1:0]   cfg_data,
	output dwvp_pkg::cfg_regs_t          cfg
);
	import dwvp_pkg::*;

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= RST_PROP_GAIN;
			cfg_q.integ_gain     <= RST_INTEG_GAIN;
			cfg_q.deriv_gain     <= RST_DERIV_GAIN;
			cfg_q.linear_scale   <= RST_SCALE;
			cfg_q.angular_scale  <= RST_SCALE;
			cfg_q.linear_target  <= RST_TARGET;
			cfg_q.angular_target <= RST_TARGET;
			cfg_q.duty_scale     <= RST_DUTY_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:     cfg_q.integ_gain     <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data[GAIN_W-1:0];
				REG_LINEAR_SCALE:   cfg_q.linear_scale   <= cfg_data;
				REG_ANGULAR_SCALE:  cfg_q.angular_scale  <= cfg_data;
				REG_LINEAR_TARGET:  cfg_q.linear_target  <= cfg_data;
				REG_ANGULAR_TARGET: cfg_q.angular_target <= cfg_data;
				REG_DUTY_SCALE:     cfg_q.duty_scale     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hdl/dwvp_ctrl.sv */
// Sequencer for the velocity PID block: accepts a sample, steps the datapath
// through both wheels for a motion sample, and owns the result valid. Depends on dwvp_pkg.
`default_nettype none
module dwvp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [dwvp_pkg::CMD_W-1:0]  command,
	input  logic                        out_stall,
	output logic                        in_stall,
	output logic                        out_valid,
	output dwvp_pkg::dp_cmd_t           dp_cmd
);
	import dwvp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   wheel_q;
	logic   out_valid_q;
	logic   motion;
	logic   accept;
	logic   load_out;

	assign motion   = (command <= CMD_BACK);
	assign accept   = in_valid && (state_q == S_IDLE);
	// result register frees up in the same cycle its beat is taken
	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_DELTA;
			wheel_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= ST_DELTA;
						wheel_q <= 1'b0;
						state_q <= motion ? S_RUN : S_FIN;
					end
				end
				S_RUN: begin
					if (step_q == ST_DUTY) begin
						if (wheel_q) begin
							state_q <= S_FIN;
						end else begin
							wheel_q <= 1'b1;
							step_q  <= ST_DELTA;
						end
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		dp_cmd.accept   = accept;
		dp_cmd.motion   = motion;
		dp_cmd.clear    = (command == CMD_CLEAR);
		dp_cmd.run      = (state_q == S_RUN);
		dp_cmd.wheel    = wheel_q;
		dp_cmd.step     = step_q;
		dp_cmd.load_out = load_out;
	end

endmodule
`default_nettype wire

/* hdl/dwvp_dp.sv */
// Datapath for the velocity PID block: per-wheel PID state, one shared
// 33x33 signed multiplier, accumulator and result register. Depends on dwvp_pkg.
`default_nettype none
module dwvp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dwvp_pkg::dp_cmd_t                dp_cmd,
	input  dwvp_pkg::cfg_regs_t              cfg,
	input  logic [dwvp_pkg::CMD_W-1:0]       command,
	input  logic [dwvp_pkg::POS_W-1:0]       left_position,
	input  logic [dwvp_pkg::POS_W-1:0]       right_position,
	output logic [dwvp_pkg::DUTY_OUT_W-1:0]  left_duty,
	output logic [dwvp_pkg::DUTY_OUT_W-1:0]  right_duty,
	output logic                             left_direction,
	output logic                             right_direction
);
	import dwvp_pkg::*;

	localparam logic signed [KIS_W-1:0] KI_LIM = KIS_W'(64'd1 << 58);
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// per-wheel state, index 0 left, 1 right
	logic [POS_W-1:0]         pos_q      [2];
	logic [POS_W-1:0]         last_pos_q [2];
	logic signed [SUM_W-1:0]  sum_q      [2];
	logic signed [31:0]       last_err_q [2];
	logic [DUTY_OUT_W-1:0]    duty_w_q   [2];
	logic                     held_l_q;
	logic                     held_r_q;
	logic                     ang_q;

	// working registers
	logic signed [31:0]       delta_q;
	logic signed [31:0]       err_q;
	logic signed [32:0]       diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [KIS_W-1:0]  kis_q;
	logic [PID_W-1:0]         pid_q;

	logic [DUTY_OUT_W-1:0]    left_duty_q;
	logic [DUTY_OUT_W-1:0]    right_duty_q;
	logic                     left_dir_q;
	logic                     right_dir_q;

	logic                     w;
	logic [REG_W-1:0]         scale;
	logic signed [REG_W-1:0]  target;
	logic signed [SUM_W-1:0]  sum_cur;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_res;
	logic signed [31:0]       speed;
	logic [32:0]              err_d;
	logic signed [31:0]       err_sat;
	logic [SUM_W:0]           sum_ext;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [KIS_W-1:0]  kis_sat;
	logic [ACC_W-18:0]        acc_sh;
	logic [PID_W-1:0]         pid_next;
	logic [DUTY_W-1:0]        duty_sat;

	assign w       = dp_cmd.wheel;
	assign scale   = ang_q ? cfg.angular_scale : cfg.linear_scale;
	assign target  = ang_q ? cfg.angular_target : cfg.linear_target;
	assign sum_cur = sum_q[w];

	// shared multiplier operand select
	always_comb begin
		case (dp_cmd.step)
			ST_MSPD: begin
				mul_a = MUL_W'(delta_q);
				mul_b = MUL_W'(scale);
			end
			ST_KP: begin
				mul_a = MUL_W'(err_q);
				mul_b = MUL_W'(cfg.prop_gain);
			end
			ST_KD: begin
				mul_a = diff_q;
				mul_b = MUL_W'(cfg.deriv_gain);
			end
			ST_KIH: begin
				mul_a = MUL_W'($signed(sum_cur[SUM_W-1 -: HI_W]));
				mul_b = MUL_W'(cfg.integ_gain);
			end
			ST_KIL: begin
				mul_a = MUL_W'(sum_cur[LO_W-1:0]);
				mul_b = MUL_W'(cfg.integ_gain);
			end
			ST_MDUTY: begin
				mul_a = MUL_W'(pid_q);
				mul_b = MUL_W'(cfg.duty_scale);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_res = mul_a * mul_b;

	always_comb begin
		// speed: product saturated to 32 bits
		if (&prod_q[PROD_W-1:31] || ~|prod_q[PROD_W-1:31])
			speed = prod_q[31:0];
		else
			speed = prod_q[PROD_W-1] ? S32_MIN : S32_MAX;

		err_d = {target[31], target} - {speed[31], speed};
		if (err_d[32] != err_d[31])
			err_sat = err_d[32] ? S32_MIN : S32_MAX;
		else
			err_sat = err_d[31:0];

		sum_ext = {sum_cur[SUM_W-1], sum_cur} + {{(SUM_W-31){err_q[31]}}, err_q};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
			sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			sum_sat = sum_ext[SUM_W-1:0];

		// integral term limited to +-2^58; past that the PID clamps anyway
		if (kis_q > KI_LIM)
			kis_sat = KI_LIM;
		else if (kis_q < -KI_LIM)
			kis_sat = -KI_LIM;
		else
			kis_sat = kis_q;

		acc_sh = acc_q[ACC_W-2:16];
		if (acc_q[ACC_W-1])
			pid_next = '0;
		else if (acc_sh > (ACC_W-17)'(PID_CAP))
			pid_next = PID_CAP;
		else
			pid_next = acc_sh[PID_W-1:0];

		if (prod_q[PROD_W-1:32] > (PROD_W-32)'(DUTY_MAX))
			duty_sat = DUTY_W'(DUTY_MAX);
		else
			duty_sat = prod_q[32 +: DUTY_W];
	end

	// architectural PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q[0] <= '0;
			last_pos_q[1] <= '0;
			sum_q[0]      <= '0;
			sum_q[1]      <= '0;
			last_err_q[0] <= '0;
			last_err_q[1] <= '0;
			held_l_q      <= 1'b0;
			held_r_q      <= 1'b0;
		end else begin
			if (dp_cmd.accept) begin
				if (dp_cmd.motion) begin
					held_l_q <= (command == CMD_FWD) || (command == CMD_LEFT);
					held_r_q <= (command == CMD_FWD) || (command == CMD_RIGHT);
				end else if (dp_cmd.clear) begin
					last_pos_q[0] <= '0;
					last_pos_q[1] <= '0;
					sum_q[0]      <= '0;
					sum_q[1]      <= '0;
					last_err_q[0] <= '0;
					last_err_q[1] <= '0;
				end
			end
			if (dp_cmd.run && dp_cmd.step == ST_KP) begin
				sum_q[w]      <= sum_sat;
				last_err_q[w] <= err_q;
				last_pos_q[w] <= pos_q[w];
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (dp_cmd.accept) begin
			pos_q[0] <= left_position;
			pos_q[1] <= right_position;
			ang_q    <= (command == CMD_LEFT) || (command == CMD_RIGHT);
			if (!dp_cmd.motion) begin
				duty_w_q[0] <= '0;
				duty_w_q[1] <= '0;
			end
		end

		if (dp_cmd.run) begin
			prod_q <= mul_res;
			case (dp_cmd.step)
				ST_DELTA: delta_q <= pos_q[w] - last_pos_q[w];
				ST_ERR:   err_q   <= err_sat;
				ST_KP:    diff_q  <= {err_q[31], err_q} - {last_err_q[w][31], last_err_q[w]};
				ST_KD:    acc_q   <= ACC_W'(prod_q);
				ST_KIH:   acc_q   <= acc_q + ACC_W'(prod_q);
				ST_KIL:   kis_q   <= KIS_W'(prod_q) <<< LO_W;
				ST_KIS:   kis_q   <= kis_q + KIS_W'(prod_q);
				ST_ACC:   acc_q   <= acc_q + ACC_W'(kis_sat);
				ST_PID:   pid_q   <= pid_next;
				ST_DUTY:  duty_w_q[w] <= duty_sat[DUTY_OUT_W-1:0];
				default: ;
			endcase
		end

		if (dp_cmd.load_out) begin
			left_duty_q  <= duty_w_q[0];
			right_duty_q <= duty_w_q[1];
			left_dir_q   <= held_l_q;
			right_dir_q  <= held_r_q;
		end
	end

	assign left_duty       = left_duty_q;
	assign right_duty      = right_duty_q;
	assign left_direction  = left_dir_q;
	assign right_direction = right_dir_q;

endmodule
`default_nettype wire

/* hdl/dual_wheel_velocity_pid_top.sv */
// Motion samples: the result follows 12 datapath steps per wheel on one shared
// 33x33 multiplier, plus the result load.
// Stop and PID-clear samples skip the datapath steps and go to the result load.
// One sample in flight; the next beat is taken while the result waits.
// arst_n clears PID state, held directions and valid; registers take defaults.
`default_nettype none
`include "dual_wheel_velocity_pid_top_defines.svh"
module dual_wheel_velocity_pid_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dwvp_pkg::IDX_W-1:0]       cfg_index,
	input  logic [dwvp_pkg::REG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dwvp_pkg::CMD_W-1:0]       command,
	input  logic [dwvp_pkg::POS_W-1:0]       left_position,
	input  logic [dwvp_pkg::POS_W-1:0]       right_position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dwvp_pkg::DUTY_OUT_W-1:0]  left_duty,
	output logic [dwvp_pkg::DUTY_OUT_W-1:0]  right_duty,
	output logic                             left_direction,
	output logic                             right_direction
);
	import dwvp_pkg::*;

	cfg_regs_t cfg;
	dp_cmd_t   dp_cmd;

	dwvp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dwvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.dp_cmd    (dp_cmd)
	);

	dwvp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.dp_cmd          (dp_cmd),
		.cfg             (cfg),
		.command         (command),
		.left_position   (left_position),
		.right_position  (right_position),
		.left_duty       (left_duty),
		.right_duty      (right_duty),
		.left_direction  (left_direction),
		.right_direction (right_direction)
	);

	// an accepted beat always leaves the block busy in the cycle after
	`DWVP_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
	// stop and clear samples never start the datapath sequence
	`DWVP_ASSERT(a_no_run_on_stop, (in_valid && !in_stall && command >= CMD_STOP) |=> !dp_cmd.run)
	// a result only appears after a sample was being worked on
	`DWVP_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall))
	`DWVP_NEVER(a_load_during_accept, dp_cmd.accept && dp_cmd.load_out)

endmodule
`default_nettype wire

/* tb/sv/dwvp_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the dual-wheel velocity PID block: tracks register writes,
// predicts duty and direction for each input beat and checks each result beat.
// Depends on dwvp_pkg for widths, command codes, register indexes and defaults.
module dwvp_checker
	import dwvp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [REG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CMD_W-1:0]      command,
	input  logic [POS_W-1:0]      left_position,
	input  logic [POS_W-1:0]      right_position,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [DUTY_OUT_W-1:0] left_duty,
	input  logic [DUTY_OUT_W-1:0] right_duty,
	input  logic                  left_direction,
	input  logic                  right_direction,
	output int                    pending,
	output int                    errors
);

	typedef struct packed {
		logic [DUTY_OUT_W-1:0] left_duty;
		logic [DUTY_OUT_W-1:0] right_duty;
		logic                  left_dir;
		logic                  right_dir;
	} drive_t;

	localparam longint S32_MAX   = 64'sd2147483647;
	localparam longint S32_MIN   = -64'sd2147483648;
	localparam longint PID_CEIL  = 64'sd10 <<< 16;
	localparam longint KI_CEIL   = 64'sd1 <<< 58;
	localparam longint SUM_LIMIT = (64'sd1 <<< (SUM_W - 1)) - 1;

	cfg_regs_t         regs;
	logic [POS_W-1:0]  last_pos [2];
	longint            err_sum [2];
	longint            last_err [2];
	logic              held_left, held_right;
	drive_t            drive_q [$];
	drive_t            want;
	logic              angular;
	logic [DUTY_OUT_W-1:0] ld, rd;

	function automatic longint clip32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// one wheel's PID step; updates that wheel's state
	function automatic logic [DUTY_OUT_W-1:0] wheel_duty(input int w,
			input logic [POS_W-1:0] pos, input logic [REG_W-1:0] scale,
			input longint target);
		logic [POS_W-1:0] d;
		longint delta, speed, err, diff, mag, ki, kiterm, acc, pid, duty;
		d = pos - last_pos[w];
		delta = longint'($signed(d));
		speed = clip32(delta * longint'(scale));
		err = clip32(target - speed);
		if (err > 0 && err_sum[w] > SUM_LIMIT - err)
			err_sum[w] = SUM_LIMIT;
		else if (err < 0 && err_sum[w] < -SUM_LIMIT - 1 - err)
			err_sum[w] = -SUM_LIMIT - 1;
		else
			err_sum[w] = err_sum[w] + err;
		diff = err - last_err[w];
		mag = (err_sum[w] < 0) ? -err_sum[w] : err_sum[w];
		ki = longint'(regs.integ_gain);
		if (ki != 0 && mag > KI_CEIL / ki)
			kiterm = KI_CEIL;
		else
			kiterm = mag * ki;
		if (err_sum[w] < 0)
			kiterm = -kiterm;
		acc = longint'(regs.prop_gain) * err + longint'(regs.deriv_gain) * diff + kiterm;
		pid = acc >>> 16;
		if (pid > PID_CEIL)
			pid = PID_CEIL;
		if (pid < 0)
			pid = 0;
		last_pos[w] = pos;
		last_err[w] = err;
		duty = (pid * longint'(regs.duty_scale)) >>> 32;
		if (duty > DUTY_MAX)
			duty = DUTY_MAX;
		return duty[DUTY_OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.prop_gain      = RST_PROP_GAIN;
			regs.integ_gain     = RST_INTEG_GAIN;
			regs.deriv_gain     = RST_DERIV_GAIN;
			regs.linear_scale   = RST_SCALE;
			regs.angular_scale  = RST_SCALE;
			regs.linear_target  = RST_TARGET;
			regs.angular_target = RST_TARGET;
			regs.duty_scale     = RST_DUTY_SCALE;
			for (int w = 0; w < 2; w++) begin
				last_pos[w] = '0;
				err_sum[w]  = 0;
				last_err[w] = 0;
			end
			held_left  = 1'b0;
			held_right = 1'b0;
			drive_q.delete();
			errors  = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROP_GAIN:      regs.prop_gain      = cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN:     regs.integ_gain     = cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN:     regs.deriv_gain     = cfg_data[GAIN_W-1:0];
					REG_LINEAR_SCALE:   regs.linear_scale   = cfg_data;
					REG_ANGULAR_SCALE:  regs.angular_scale  = cfg_data;
					REG_LINEAR_TARGET:  regs.linear_target  = cfg_data;
					REG_ANGULAR_TARGET: regs.angular_target = cfg_data;
					REG_DUTY_SCALE:     regs.duty_scale     = cfg_data;
					default: ;
				endcase
			end

			// result beat belongs to an older sample, so check before queueing
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$error("result beat with no sample outstanding");
					errors++;
				end else begin
					want = drive_q.pop_front();
					if (left_duty !== want.left_duty) begin
						$error("left_duty: expected %0d, got %0d", want.left_duty, left_duty);
						errors++;
					end
					if (right_duty !== want.right_duty) begin
						$error("right_duty: expected %0d, got %0d", want.right_duty, right_duty);
						errors++;
					end
					if (left_direction !== want.left_dir) begin
						$error("left_direction: expected %0d, got %0d", want.left_dir,
							left_direction);
						errors++;
					end
					if (right_direction !== want.right_dir) begin
						$error("right_direction: expected %0d, got %0d", want.right_dir,
							right_direction);
						errors++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				ld = '0;
				rd = '0;
				if (command <= CMD_BACK) begin
					angular = (command == CMD_LEFT || command == CMD_RIGHT);
					ld = wheel_duty(0, left_position,
						angular ? regs.angular_scale : regs.linear_scale,
						longint'(angular ? regs.angular_target : regs.linear_target));
					rd = wheel_duty(1, right_position,
						angular ? regs.angular_scale : regs.linear_scale,
						longint'(angular ? regs.angular_target : regs.linear_target));
					held_left  = (command == CMD_FWD || command == CMD_LEFT);
					held_right = (command == CMD_FWD || command == CMD_RIGHT);
				end else if (command == CMD_CLEAR) begin
					// held directions survive a PID clear
					for (int w = 0; w < 2; w++) begin
						last_pos[w] = '0;
						err_sum[w]  = 0;
						last_err[w] = 0;
					end
				end
				drive_q.push_back('{ld, rd, held_left, held_right});
			end
			pending <= drive_q.size();
		end
	end

endmodule

/* tb/sv/tb_dual_wheel_velocity_pid_top.sv */
`timescale 1ns / 1ps
// Top of the dual-wheel velocity PID testbench: clock, reset, register setup and
// sample stimulus with random idling; checking is done by dwvp_checker.
// Depends on dwvp_pkg, dwvp_checker and dual_wheel_velocity_pid_top.
module tb_dual_wheel_velocity_pid_top;
	import dwvp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      command = '0;
	logic [POS_W-1:0]      left_position = '0;
	logic [POS_W-1:0]      right_position = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DUTY_OUT_W-1:0] left_duty, right_duty;
	logic                  left_direction, right_direction;
	int                    pending, errors;

	// shared between the sample driver and the result-side throttle
	bit idle_on = 1'b1;
	int hold_cycles = 0;

	int n_samples = 0;
	int n_stop = 0;
	int n_clear = 0;
	int n_settings = 1;

	localparam int HOLD_LEN = 400;

	dual_wheel_velocity_pid_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .left_position(left_position), .right_position(right_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_duty(left_duty), .right_duty(right_duty),
		.left_direction(left_direction), .right_direction(right_direction)
	);

	dwvp_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .left_position(left_position), .right_position(right_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_duty(left_duty), .right_duty(right_duty),
		.left_direction(left_direction), .right_direction(right_direction),
		.pending(pending), .errors(errors)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// valid is left high after a beat; the next call lowers it only for a gap
	task automatic send_sample(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] lp,
			input logic [POS_W-1:0] rp);
		while (idle_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= c;
		left_position  <= lp;
		right_position <= rp;
		do @(posedge clk); while (in_stall);
		n_samples++;
		case (c)
			CMD_STOP:  n_stop++;
			CMD_CLEAR: n_clear++;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_config(input cfg_regs_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_PROP_GAIN;      cfg_data <= REG_W'(c.prop_gain);  @(posedge clk);
		cfg_index <= REG_INTEG_GAIN;     cfg_data <= REG_W'(c.integ_gain); @(posedge clk);
		cfg_index <= REG_DERIV_GAIN;     cfg_data <= REG_W'(c.deriv_gain); @(posedge clk);
		cfg_index <= REG_LINEAR_SCALE;   cfg_data <= c.linear_scale;       @(posedge clk);
		cfg_index <= REG_ANGULAR_SCALE;  cfg_data <= c.angular_scale;      @(posedge clk);
		cfg_index <= REG_LINEAR_TARGET;  cfg_data <= c.linear_target;      @(posedge clk);
		cfg_index <= REG_ANGULAR_TARGET; cfg_data <= c.angular_target;     @(posedge clk);
		cfg_index <= REG_DUTY_SCALE;     cfg_data <= c.duty_scale;         @(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_side
		int n;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= idle_on && ($urandom_range(99) < 18);
		end
	end

	initial begin : stimulus
		cfg_regs_t        c;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] lwalk, rwalk;
		int               r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: each command, wrapping and saturating count deltas
		send_sample(CMD_FWD, 32'd0, 32'd0);
		send_sample(CMD_FWD, 32'd1, 32'd1);
		send_sample(CMD_LEFT, 32'd3, 32'd2);
		send_sample(CMD_RIGHT, 32'd4, 32'd6);
		send_sample(CMD_BACK, 32'd2, 32'd5);
		send_sample(CMD_STOP, 32'd9, 32'd9);
		send_sample(CMD_FWD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_sample(CMD_BACK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(CMD_CLEAR, 32'h1234_5678, 32'h8765_4321);
		send_sample(CMD_LEFT, 32'h8000_0000, 32'h0000_0001);
		send_sample(CMD_RIGHT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sample(CMD_STOP, 32'd0, 32'd0);

		// every register at full scale
		drain();
		c = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		program_config(c);
		send_sample(CMD_FWD, 32'd0, 32'd0);
		send_sample(CMD_FWD, 32'd1, 32'hFFFF_FFFF);
		send_sample(CMD_LEFT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_sample(CMD_BACK, 32'h5555_5555, 32'hAAAA_AAAA);
		send_sample(CMD_RIGHT, 32'd10, 32'd10);
		send_sample(CMD_CLEAR, 32'd0, 32'd0);
		send_sample(CMD_FWD, 32'd0, 32'd0);

		// zero gains and scales, most negative targets
		drain();
		c = '{24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0};
		program_config(c);
		send_sample(CMD_FWD, 32'd5, 32'd5);
		send_sample(CMD_LEFT, 32'd0, 32'd0);
		send_sample(CMD_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(CMD_BACK, 32'd1, 32'd2);
		send_sample(CMD_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		lwalk = $urandom;
		rwalk = $urandom;
		for (int p = 0; p < 6; p++) begin
			drain();
			if (p == 4) begin
				c.prop_gain      = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
				c.integ_gain     = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
				c.deriv_gain     = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
				c.linear_scale   = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				c.angular_scale  = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				c.linear_target  = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				c.angular_target = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				c.duty_scale     = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			end else begin
				// gains and targets in a range where duty lands between the clamps
				c.prop_gain      = GAIN_W'($urandom_range(4 << 16));
				c.integ_gain     = GAIN_W'($urandom_range(1 << 16));
				c.deriv_gain     = GAIN_W'($urandom_range(16 << 16));
				c.linear_scale   = $urandom_range(4 << 16, 1 << 14);
				c.angular_scale  = $urandom_range(4 << 16, 1 << 14);
				c.linear_target  = $urandom_range(16 << 16) - (8 << 16);
				c.angular_target = $urandom_range(16 << 16) - (8 << 16);
				c.duty_scale     = $urandom_range(500 << 16, 100 << 16);
			end
			program_config(c);
			idle_on = (p != 3);
			for (int i = 0; i < 250; i++) begin
				if (p == 2 && i == 30)
					hold_cycles = HOLD_LEN;
				r = $urandom_range(99);
				if (r < 8)
					cmd = CMD_STOP;
				else if (r < 12)
					cmd = CMD_CLEAR;
				else
					cmd = CMD_W'($urandom_range(3));
				// mostly small count steps, sometimes a jump anywhere
				if ($urandom_range(99) < 10) begin
					lwalk = $urandom;
					rwalk = $urandom;
				end else begin
					lwalk = lwalk + $urandom_range(12) - 2;
					rwalk = rwalk + $urandom_range(12) - 2;
				end
				send_sample(cmd, lwalk, rwalk);
			end
		end
		idle_on = 1'b1;

		drain();
		repeat (30) @(posedge clk);
		$display("Checked %0d control samples (%0d stop, %0d PID clear) over %0d settings,",
			n_samples, n_stop, n_clear, n_settings);
		$display("including zero and full-scale registers, a %0d-cycle output hold-off%s",
			HOLD_LEN, " and an unthrottled run.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#1_500_000;
		$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/dwvp_pkg.sv
hdl/dwvp_regs.sv
hdl/dwvp_ctrl.sv
hdl/dwvp_dp.sv
hdl/dual_wheel_velocity_pid_top.sv
tb/sv/dwvp_checker.sv
tb/sv/tb_dual_wheel_velocity_pid_top.sv
